[rtl/radix_int_to_ascii_top_defines.svh]
// Assertion macros shared by the radix integer-to-text converter RTL.
// Included by the controller and datapath files; no other dependencies.
`ifndef RADIX_INT_TO_ASCII_TOP_DEFINES_SVH
`define RADIX_INT_TO_ASCII_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property at every clock edge outside reset
`define RITOA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ritoa assertion failed");
// Check a property at every clock edge, reset included
`define RITOA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ritoa assertion failed");
`else
`define RITOA_ASSERT(lbl, clk, rst_n, prop)
`define RITOA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[rtl/ritoa_pkg.sv]
// Shared constants, register indexes and controller/datapath interface types
// for the radix integer-to-text converter. No dependencies.
`default_nettype none

package ritoa_pkg;

    // Operand and field widths
    localparam int VALUE_BITS_DEF = 64;
    localparam int VALUE_W        = 64;
    localparam int OPW_W          = 2;
    localparam int TUSER_IN_W     = 3;
    localparam int CHAR_W         = 7;
    localparam int TDATA_OUT_W    = 8;
    localparam int MAX_CHARS      = 64;

    // Divider processes this many dividend bits per cycle
    localparam int DIV_STEP       = 8;

    // Configuration port
    localparam int RADIX_W        = 6;
    localparam int CFG_ADDR_W     = 1;
    localparam int CFG_DATA_W     = 6;
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIX = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_UPPER = 1'b1;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;

    // Operand width codes
    localparam logic [OPW_W-1:0] OPW_8  = 2'd0;
    localparam logic [OPW_W-1:0] OPW_16 = 2'd1;
    localparam logic [OPW_W-1:0] OPW_32 = 2'd2;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;    // capture operand, clear digit count
        logic div_step;     // run one divider chunk
        logic store_digit;  // write remainder digit, restart divider
        logic sign_out;     // load '-' into the output register
        logic digit_out;    // load stored digit into the output register
        logic empty_out;    // load the empty marker result
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic radix_ok;     // configured radix within 2..36
        logic neg;          // current item is negative
        logic div_done;     // this step is the last chunk of the dividend
        logic quot_zero;    // quotient is zero
        logic out_free;     // output register can take a character
        logic digit_last;   // read pointer sits on the final digit
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/ritoa_ctrl.sv]
// Controller state machine of the radix integer-to-text converter.
// Depends on ritoa_pkg and radix_int_to_ascii_top_defines.svh.
`default_nettype none
`include "radix_int_to_ascii_top_defines.svh"

module ritoa_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  ritoa_pkg::dp_status_t   status,
    output ritoa_pkg::ctrl_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_STORE = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_RD    = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam logic [2:0] ST_EMPTY = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Accept a transaction only between items
    assign s_tready = (state_reg == ST_IDLE);

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = status.radix_ok ? ST_DIV : ST_EMPTY;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store_digit = 1'b1;
                if (!status.quot_zero) begin
                    state_next = ST_DIV;
                end else if (status.neg) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_SIGN: begin
                if (status.out_free) begin
                    cmd.sign_out = 1'b1;
                    state_next   = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.digit_out = 1'b1;
                    state_next    = status.digit_last ? ST_IDLE : ST_RD;
                end
            end
            ST_EMPTY: begin
                if (status.out_free) begin
                    cmd.empty_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A digit is written only right after the last divider chunk
    `RITOA_ASSERT(a_store_after_step, aclk, aresetn, cmd.store_digit |-> $past(cmd.div_step))
    // Characters go out only when the output register is free
    `RITOA_ASSERT(a_out_when_free, aclk, aresetn,
        (cmd.digit_out || cmd.sign_out || cmd.empty_out) |-> status.out_free)
    // The empty marker appears only for an unusable radix
    `RITOA_ASSERT(a_empty_bad_radix, aclk, aresetn, cmd.empty_out |-> !status.radix_ok)

endmodule

`default_nettype wire

[rtl/ritoa_dpath.sv]
// Datapath of the radix integer-to-text converter: configuration registers,
// chunked radix divider, digit memory and output register. Depends on ritoa_pkg.
`default_nettype none
`include "radix_int_to_ascii_top_defines.svh"

module ritoa_dpath #(
    parameter int VALUE_BITS = ritoa_pkg::VALUE_BITS_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_we,
    input  wire  [ritoa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire  [ritoa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire  [ritoa_pkg::VALUE_W-1:0]        s_tdata,
    input  wire  [ritoa_pkg::TUSER_IN_W-1:0]     s_tuser,
    input  ritoa_pkg::ctrl_cmd_t                 cmd,
    output ritoa_pkg::dp_status_t                status,
    input  wire                                  m_tready,
    output logic                                 m_tvalid,
    output logic [ritoa_pkg::TDATA_OUT_W-1:0]    m_tdata,
    output logic                                 m_tuser,
    output logic                                 m_tlast
);

    localparam int STEP   = ritoa_pkg::DIV_STEP;
    localparam int CHUNKS = (VALUE_BITS + STEP - 1) / STEP;
    localparam int QW     = CHUNKS * STEP;
    localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int AW     = $clog2(VALUE_BITS);
    localparam int NW     = $clog2(VALUE_BITS + 1);
    localparam int RW     = ritoa_pkg::RADIX_W;
    localparam int CW     = ritoa_pkg::CHAR_W;
    localparam bit TRUNC_POSSIBLE = (VALUE_BITS >= ritoa_pkg::MAX_CHARS);

    // Configuration registers
    logic [RW-1:0] radix_reg;
    logic          upper_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= ritoa_pkg::RADIX_RESET;
            upper_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                ritoa_pkg::CFG_RADIX: radix_reg <= cfg_wdata[RW-1:0];
                ritoa_pkg::CFG_UPPER: upper_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Operand masking and negation within the selected width
    logic [ritoa_pkg::VALUE_W-1:0] width_mask;
    logic [VALUE_BITS-1:0]         mag_raw;
    logic [VALUE_BITS-1:0]         mag_in;

    always_comb begin
        case (s_tuser[ritoa_pkg::OPW_W-1:0])
            ritoa_pkg::OPW_8:  width_mask = 64'h0000_0000_0000_00FF;
            ritoa_pkg::OPW_16: width_mask = 64'h0000_0000_0000_FFFF;
            ritoa_pkg::OPW_32: width_mask = 64'h0000_0000_FFFF_FFFF;
            default:           width_mask = '1;
        endcase
        mag_raw = s_tdata[VALUE_BITS-1:0] & width_mask[VALUE_BITS-1:0];
        if (s_tuser[ritoa_pkg::OPW_W]) begin
            mag_in = (~mag_raw + 1'b1) & width_mask[VALUE_BITS-1:0];
        end else begin
            mag_in = mag_raw;
        end
    end

    // Divider: quotient shifts in a chunk of bits each step, remainder stays below radix
    logic [QW-1:0]    q_reg;
    logic [QW-1:0]    q_next;
    logic [RW-1:0]    rem_reg;
    logic [RW-1:0]    rem_next;
    logic [CNT_W-1:0] chunk_reg;
    logic             neg_reg;
    logic [STEP-1:0]  qbits;
    logic [RW:0]      trial;
    logic [RW-1:0]    rem_step;

    always_comb begin
        rem_step = rem_reg;
        qbits    = '0;
        trial    = '0;
        for (int i = 0; i < STEP; i++) begin
            trial = {rem_step, q_reg[QW-1-i]};
            if (trial >= {1'b0, radix_reg}) begin
                trial          = trial - {1'b0, radix_reg};
                qbits[STEP-1-i] = 1'b1;
            end
            rem_step = trial[RW-1:0];
        end
    end

    always_comb begin
        q_next   = q_reg;
        rem_next = rem_reg;
        if (cmd.load_item) begin
            q_next   = QW'(mag_in);
            rem_next = '0;
        end else if (cmd.div_step) begin
            q_next   = (q_reg << STEP) | QW'(qbits);
            rem_next = rem_step;
        end else if (cmd.store_digit) begin
            rem_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (cmd.load_item) begin
            neg_reg <= s_tuser[ritoa_pkg::OPW_W];
        end
    end

    // Chunk counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_reg <= '0;
        end else if (cmd.load_item || cmd.store_digit) begin
            chunk_reg <= '0;
        end else if (cmd.div_step) begin
            chunk_reg <= chunk_reg + 1'b1;
        end
    end

    // Digit character from the remainder
    logic [CW-1:0] digit_char;

    always_comb begin
        if (rem_reg < ritoa_pkg::DEC_DIGITS) begin
            digit_char = ritoa_pkg::CHAR_ZERO + CW'(rem_reg);
        end else begin
            digit_char = (upper_reg ? ritoa_pkg::CHAR_UPPER : ritoa_pkg::CHAR_LOWER)
                         + CW'(rem_reg - ritoa_pkg::DEC_DIGITS);
        end
    end

    // Digit memory, least significant digit at address zero
    logic [CW-1:0] digit_mem [VALUE_BITS];
    logic [CW-1:0] rd_data_reg;
    logic [NW-1:0] ndig_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] stop_idx;

    always_ff @(posedge aclk) begin
        if (cmd.store_digit) begin
            digit_mem[ndig_reg[AW-1:0]] <= digit_char;
        end
        rd_data_reg <= digit_mem[rd_idx_reg];
    end

    // Digit count and read pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ndig_reg   <= '0;
            rd_idx_reg <= '0;
        end else if (cmd.load_item) begin
            ndig_reg <= '0;
        end else if (cmd.store_digit) begin
            ndig_reg   <= ndig_reg + 1'b1;
            rd_idx_reg <= ndig_reg[AW-1:0];
        end else if (cmd.digit_out) begin
            rd_idx_reg <= rd_idx_reg - 1'b1;
        end
    end

    // Drop the least significant digit when sign plus digits overflow the text length
    always_comb begin
        if (TRUNC_POSSIBLE && neg_reg && (ndig_reg == NW'(ritoa_pkg::MAX_CHARS))) begin
            stop_idx = AW'(1);
        end else begin
            stop_idx = '0;
        end
    end

    // Output register
    logic          out_valid_reg;
    logic [CW-1:0] out_char_reg;
    logic          out_empty_reg;
    logic          out_last_reg;
    logic          out_free;
    logic          digit_last;

    assign out_free   = !out_valid_reg || m_tready;
    assign digit_last = (rd_idx_reg == stop_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.sign_out || cmd.digit_out || cmd.empty_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sign_out) begin
            out_char_reg  <= ritoa_pkg::CHAR_MINUS;
            out_empty_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end else if (cmd.digit_out) begin
            out_char_reg  <= rd_data_reg;
            out_empty_reg <= 1'b0;
            out_last_reg  <= digit_last;
        end else if (cmd.empty_out) begin
            out_char_reg  <= ritoa_pkg::CHAR_NONE;
            out_empty_reg <= 1'b1;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tuser  = out_empty_reg;
    assign m_tlast  = out_last_reg;

    // Status to the controller
    always_comb begin
        status            = '0;
        status.radix_ok   = (radix_reg >= ritoa_pkg::RADIX_MIN)
                            && (radix_reg <= ritoa_pkg::RADIX_MAX);
        status.neg        = neg_reg;
        status.div_done   = (chunk_reg == CNT_W'(CHUNKS - 1));
        status.quot_zero  = (q_reg == '0);
        status.out_free   = out_free;
        status.digit_last = digit_last;
    end

    // Remainder stays below the radix while dividing
    `RITOA_ASSERT(a_rem_below_radix, aclk, aresetn, cmd.div_step |-> (rem_reg < radix_reg))
    // Digit count never passes the operand width
    `RITOA_ASSERT(a_ndig_bound, aclk, aresetn, ndig_reg <= NW'(VALUE_BITS))
    // An empty marker is always the final result
    `RITOA_ASSERT(a_empty_is_last, aclk, aresetn, (out_valid_reg && out_empty_reg) |-> out_last_reg)

endmodule

`default_nettype wire

[rtl/radix_int_to_ascii_top.sv]
// Radix integer-to-text converter, radix 2..36, one ASCII character per transaction.
// Each digit runs the chunked divider over every dividend chunk, then stores the remainder.
// Characters then go out through the digit memory read port, most significant first, after any '-'.
// An invalid radix yields a single empty marker result instead of characters.
// Reset (aresetn, synchronous, active low) sets radix 10, lower case, and idles.
`default_nettype none

module radix_int_to_ascii_top #(
    parameter int VALUE_BITS = ritoa_pkg::VALUE_BITS_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // Configuration write port
    input  wire                                  cfg_we,
    input  wire  [ritoa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire  [ritoa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input stream
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [ritoa_pkg::VALUE_W-1:0]        s_tdata,   // [63:0] value
    input  wire  [ritoa_pkg::TUSER_IN_W-1:0]     s_tuser,   // [1:0] operand_width, [2] is_negative
    // Result stream
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [ritoa_pkg::TDATA_OUT_W-1:0]    m_tdata,   // [6:0] char_code, [7] zero
    output logic                                 m_tuser,   // [0] empty_res
    output logic                                 m_tlast
);

    ritoa_pkg::ctrl_cmd_t  cmd;
    ritoa_pkg::dp_status_t status;

    ritoa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ritoa_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
